// ----- rtl/core/sppd_pkg.sv -----
// shared constants, types and a modular addition helper for the partial derivative block
package sppd_pkg;

    localparam int FIELD_DEGREE = 4;
    localparam int DATA_W       = 64;
    localparam int CNT_W        = 32;
    localparam int RED_LAT      = DATA_W;
    localparam int MUL_LAT      = DATA_W;
    localparam int CFG_IDX_W    = 2;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PRIME = 2'd0;
    localparam t_cfg_idx CFG_SHIFT = 2'd1;
    localparam t_cfg_idx CFG_WIDTH = 2'd2;

    // x + y mod p with x, y below p; p of zero means mod 2^64
    function automatic t_word add_mod(input t_word x, input t_word y, input t_word p);
        logic [DATA_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[DATA_W] || (s[DATA_W-1:0] >= p)) begin
            return s[DATA_W-1:0] - p;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/core/sppd_modred.sv -----
// pipelined restoring reduction of one word mod p, one bit per stage
module sppd_modred
    import sppd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_p,
    input  t_word i_val,
    output t_word o_res
);

    t_word r_val [RED_LAT];
    t_word r_rem [RED_LAT];

    for (genvar k = 0; k < RED_LAT; k++) begin : g_stage
        t_word           prev_rem;
        t_word           prev_val;
        logic [DATA_W:0] t;
        logic [DATA_W:0] d;
        t_word           n_rem;

        assign prev_rem = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
        assign prev_val = (k == 0) ? i_val : r_val[(k == 0) ? 0 : k-1];
        assign t        = {prev_rem, prev_val[DATA_W-1-k]};
        assign d        = t - {1'b0, i_p};

        always_comb begin
            if (t >= {1'b0, i_p}) begin
                n_rem = d[DATA_W-1:0];
            end else begin
                n_rem = t[DATA_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_val[k] <= prev_val;
            end
        end
    end

    // zero modulus: no reduction
    assign o_res = (i_p == '0) ? r_val[RED_LAT-1] : r_rem[RED_LAT-1];

endmodule

// ----- rtl/core/sppd_mulmod.sv -----
// pipelined double-and-add modular multiplier, one multiplier bit per stage
module sppd_mulmod
    import sppd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_p,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_res
);

    t_word r_a [MUL_LAT];
    t_word r_b [MUL_LAT];
    t_word r_r [MUL_LAT];

    for (genvar k = 0; k < MUL_LAT; k++) begin : g_stage
        t_word prev_r;
        t_word prev_a;
        t_word prev_b;
        t_word dbl;
        t_word n_r;

        assign prev_r = (k == 0) ? '0 : r_r[(k == 0) ? 0 : k-1];
        assign prev_a = (k == 0) ? i_a : r_a[(k == 0) ? 0 : k-1];
        assign prev_b = (k == 0) ? i_b : r_b[(k == 0) ? 0 : k-1];
        assign dbl    = add_mod(prev_r, prev_r, i_p);
        assign n_r    = prev_b[DATA_W-1-k] ? add_mod(dbl, prev_a, i_p) : dbl;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= n_r;
                r_a[k] <= prev_a;
                r_b[k] <= prev_b;
            end
        end
    end

    assign o_res = r_r[MUL_LAT-1];

endmodule

// ----- rtl/core/sparse_poly_partial_derivative.sv -----
// top level: partial derivative of a sparse polynomial over GF(p^n), one term per request
// Usage:
//   Input channel (i_valid / o_stall) takes one term per request: four coefficient
//   residues, the packed exponent word and the last mark. Output channel
//   (o_valid / i_stall) gives one result per request, in order.
//   Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) writes modulus, field shift and
//   field width; write only while no request is in flight.
//   Throughput: one request per cycle while the output is not stalled. Each request
//   passes a 64-stage pipelined reduction mod p, then a 64-stage pipelined
//   double-and-add multiplier, then the output register. All lanes (one per
//   residue, one for the exponent field) run side by side.
//   The whole pipeline moves as one; it holds when a result is shown and
//   i_stall is high, and o_stall then follows i_stall. Bubbles travel along.
//   Reset clears the pipeline valid bits, the kept counter and the registers
//   (modulus 2, shift 0, width 8). The kept counter returns to zero after
//   each result that carries the last mark.
module sparse_poly_partial_derivative
    import sppd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [63:0]          i_coeff_0,
    input  logic [63:0]          i_coeff_1,
    input  logic [63:0]          i_coeff_2,
    input  logic [63:0]          i_coeff_3,
    input  logic [63:0]          i_exponent_word,
    input  logic                 i_last_term,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [63:0]          o_out_coeff_0,
    output logic [63:0]          o_out_coeff_1,
    output logic [63:0]          o_out_coeff_2,
    output logic [63:0]          o_out_coeff_3,
    output logic [63:0]          o_out_exponent,
    output logic                 o_keep,
    output logic                 o_out_last,
    output logic [31:0]          o_kept_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    t_word       r_prime;
    logic [5:0]  r_shift;
    logic [6:0]  r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= t_word'(2);
            r_shift <= 6'd0;
            r_width <= 7'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRIME: r_prime <= i_cfg_data;
                CFG_SHIFT: r_shift <= i_cfg_data[5:0];
                CFG_WIDTH: r_width <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // exponent field extraction
    t_word mask;
    t_word field;
    t_word exp_dec;
    always_comb begin
        if (r_width == 7'd0) begin
            mask = '0;
        end else if (r_width >= 7'd64) begin
            mask = '1;
        end else begin
            mask = (t_word'(1) << r_width[5:0]) - t_word'(1);
        end
    end
    assign field   = (i_exponent_word >> r_shift) & mask;
    assign exp_dec = i_exponent_word - (t_word'(1) << r_shift);

    t_word coeff_in  [FIELD_DEGREE];
    t_word coeff_red [FIELD_DEGREE];
    t_word coeff_mul [FIELD_DEGREE];
    t_word field_red;

    assign coeff_in[0] = i_coeff_0;
    assign coeff_in[1] = i_coeff_1;
    assign coeff_in[2] = i_coeff_2;
    assign coeff_in[3] = i_coeff_3;

    sppd_modred u_field_red (
        .i_clk (i_clk),
        .i_en  (en),
        .i_p   (r_prime),
        .i_val (field),
        .o_res (field_red)
    );

    for (genvar l = 0; l < FIELD_DEGREE; l++) begin : g_lane
        sppd_modred u_red (
            .i_clk (i_clk),
            .i_en  (en),
            .i_p   (r_prime),
            .i_val (coeff_in[l]),
            .o_res (coeff_red[l])
        );
        sppd_mulmod u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_p   (r_prime),
            .i_a   (coeff_red[l]),
            .i_b   (field_red),
            .o_res (coeff_mul[l])
        );
    end

    // sideband through the reduction stages
    logic  r_sa_v    [RED_LAT];
    logic  r_sa_last [RED_LAT];
    logic  r_sa_nz   [RED_LAT];
    t_word r_sa_exp  [RED_LAT];
    // sideband through the multiplier stages
    logic  r_sb_v    [MUL_LAT];
    logic  r_sb_last [MUL_LAT];
    logic  r_sb_keep [MUL_LAT];
    t_word r_sb_exp  [MUL_LAT];

    logic keep_mid;
    assign keep_mid = r_sa_nz[RED_LAT-1] && (field_red != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RED_LAT; k++) r_sa_v[k] <= 1'b0;
            for (int k = 0; k < MUL_LAT; k++) r_sb_v[k] <= 1'b0;
        end else if (en) begin
            r_sa_v[0] <= i_valid;
            for (int k = 1; k < RED_LAT; k++) r_sa_v[k] <= r_sa_v[k-1];
            r_sb_v[0] <= r_sa_v[RED_LAT-1];
            for (int k = 1; k < MUL_LAT; k++) r_sb_v[k] <= r_sb_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa_last[0] <= i_last_term;
            r_sa_nz[0]   <= (field != '0);
            r_sa_exp[0]  <= exp_dec;
            for (int k = 1; k < RED_LAT; k++) begin
                r_sa_last[k] <= r_sa_last[k-1];
                r_sa_nz[k]   <= r_sa_nz[k-1];
                r_sa_exp[k]  <= r_sa_exp[k-1];
            end
            r_sb_last[0] <= r_sa_last[RED_LAT-1];
            r_sb_keep[0] <= keep_mid;
            r_sb_exp[0]  <= r_sa_exp[RED_LAT-1];
            for (int k = 1; k < MUL_LAT; k++) begin
                r_sb_last[k] <= r_sb_last[k-1];
                r_sb_keep[k] <= r_sb_keep[k-1];
                r_sb_exp[k]  <= r_sb_exp[k-1];
            end
        end
    end

    // output register and running count
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             keep_end;
    assign keep_end = r_sb_keep[MUL_LAT-1];
    assign n_cnt    = r_cnt + CNT_W'(keep_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (en) begin
            o_valid <= r_sb_v[MUL_LAT-1];
            if (r_sb_v[MUL_LAT-1]) begin
                r_cnt <= r_sb_last[MUL_LAT-1] ? '0 : n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_coeff_0  <= keep_end ? coeff_mul[0] : '0;
            o_out_coeff_1  <= keep_end ? coeff_mul[1] : '0;
            o_out_coeff_2  <= keep_end ? coeff_mul[2] : '0;
            o_out_coeff_3  <= keep_end ? coeff_mul[3] : '0;
            o_out_exponent <= keep_end ? r_sb_exp[MUL_LAT-1] : '0;
            o_keep         <= keep_end;
            o_out_last     <= r_sb_last[MUL_LAT-1];
            o_kept_count   <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/sppd_checker.sv -----
// port-level checker for the partial derivative block, bound to the top level
module sppd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_out_coeff_0,
    input logic [63:0] o_out_exponent,
    input logic        o_keep,
    input logic [31:0] o_kept_count
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_keep) |-> (o_out_coeff_0 == 64'd0 && o_out_exponent == 64'd0))
        else $error("dropped term carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kept_count) && $stable(o_keep)))
        else $error("stalled result changed");

endmodule

bind sparse_poly_partial_derivative sppd_checker u_sppd_checker (.*);

// ----- dv/tb_sparse_poly_partial_derivative.sv -----
// testbench for the sparse polynomial partial derivative block: directed table, random terms
`timescale 1ns / 1ps
module tb_sparse_poly_partial_derivative
    import sppd_pkg::*;
();

    typedef struct {
        logic [63:0] coeff [4];
        logic [63:0] expw;
        logic        last;
    } t_term;

    typedef struct {
        logic [63:0] coeff [4];
        logic [63:0] expw;
        logic        keep;
        logic        last;
        logic [31:0] count;
    } t_deriv;

    typedef struct {
        t_term  t;
        logic   has_exp;
        t_deriv e;
    } t_row;

    localparam int LATENCY = 129;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_coeff_0, i_coeff_1, i_coeff_2, i_coeff_3, i_exponent_word;
    logic        i_last_term;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_out_coeff_0, o_out_coeff_1, o_out_coeff_2, o_out_coeff_3;
    logic [63:0] o_out_exponent;
    logic        o_keep, o_out_last;
    logic [31:0] o_kept_count;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [63:0] i_cfg_data;

    sparse_poly_partial_derivative i_dut (.*);

    // predictor state
    logic [63:0] m_prime;
    logic [5:0]  m_shift;
    logic [6:0]  m_width;
    logic [31:0] m_kept;

    t_deriv pending_q [$];
    t_row   directed [$];
    int     errors;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    bit     done_sending;

    function automatic logic [63:0] reduce_p(logic [63:0] a);
        if (m_prime == 64'd0) return a;
        return a % m_prime;
    endfunction

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        if (m_prime == 64'd0) return a * b;
        prod = {64'd0, a % m_prime} * {64'd0, b % m_prime};
        prod = prod % {64'd0, m_prime};
        return prod[63:0];
    endfunction

    function automatic t_deriv differentiate(t_term t);
        t_deriv      d;
        logic [6:0]  w;
        logic [63:0] mask, fld, fr;
        w = (m_width > 7'd64) ? 7'd64 : m_width;
        mask = (w == 7'd0) ? 64'd0 : ({64{1'b1}} >> (7'd64 - w));
        fld = (t.expw >> m_shift) & mask;
        fr = reduce_p(fld);
        d.keep = (fld != 64'd0) && (fr != 64'd0);
        if (d.keep) begin
            m_kept = m_kept + 32'd1;
            for (int i = 0; i < 4; i++) d.coeff[i] = mulmod(t.coeff[i], fr);
            d.expw = t.expw - (64'd1 << m_shift);
        end else begin
            for (int i = 0; i < 4; i++) d.coeff[i] = '0;
            d.expw = '0;
        end
        d.last = t.last;
        d.count = m_kept;
        if (t.last) m_kept = '0;
        return d;
    endfunction

    function automatic bit same_deriv(t_deriv p, t_deriv q);
        for (int i = 0; i < 4; i++)
            if (p.coeff[i] !== q.coeff[i]) return 1'b0;
        return (p.expw === q.expw) && (p.keep === q.keep) && (p.last === q.last) &&
               (p.count === q.count);
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PRIME: m_prime = val;
            CFG_SHIFT: m_shift = val[5:0];
            CFG_WIDTH: m_width = val[6:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // offers one term and holds it until accepted
    task automatic send_term(t_term t, logic has_exp, t_deriv e);
        t_deriv d;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coeff_0 <= t.coeff[0];
        i_coeff_1 <= t.coeff[1];
        i_coeff_2 <= t.coeff[2];
        i_coeff_3 <= t.coeff[3];
        i_exponent_word <= t.expw;
        i_last_term <= t.last;
        do @(posedge i_clk); while (o_stall);
        d = differentiate(t);
        if (has_exp) begin
            if (!same_deriv(d, e)) begin
                $display("%0t directed row disagrees: expected %p, actual %p", $time, e, d);
                errors++;
            end
        end
        pending_q.push_back(d);
    endtask

    function automatic t_term rand_term(int sz);
        t_term t;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(3))
                0: t.coeff[i] = {$urandom, $urandom};
                1: t.coeff[i] = (m_prime == 64'd0) ? {$urandom, $urandom} :
                                {$urandom, $urandom} % m_prime;
                2: t.coeff[i] = {64{1'b1}};
                default: t.coeff[i] = 64'($urandom_range(3));
            endcase
        end
        t.expw = {$urandom, $urandom};
        if (sz == 0 && $urandom_range(3) == 0) t.expw = t.expw & ~({64{1'b1}} << m_shift);
        t.last = ($urandom_range(15) == 0);
        return t;
    endfunction

    function automatic t_row mk(logic [63:0] c, logic [63:0] x, logic l, logic h,
                                logic [63:0] ec, logic [63:0] ex, logic k, logic [31:0] n);
        t_row r;
        for (int i = 0; i < 4; i++) begin
            r.t.coeff[i] = c;
            r.e.coeff[i] = ec;
        end
        r.t.expw = x;
        r.t.last = l;
        r.has_exp = h;
        r.e.expw = ex;
        r.e.keep = k;
        r.e.last = l;
        r.e.count = n;
        return r;
    endfunction

    // checker
    always @(posedge i_clk) begin
        t_deriv a, x;
        if (i_rst_n && o_valid && !i_stall) begin
            a.coeff[0] = o_out_coeff_0;
            a.coeff[1] = o_out_coeff_1;
            a.coeff[2] = o_out_coeff_2;
            a.coeff[3] = o_out_coeff_3;
            a.expw = o_out_exponent;
            a.keep = o_keep;
            a.last = o_out_last;
            a.count = o_kept_count;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %p", $time, a);
                errors++;
            end else begin
                x = pending_q.pop_front();
                for (int i = 0; i < 4; i++)
                    if (a.coeff[i] !== x.coeff[i]) begin
                        $display("%0t coeff_%0d: expected %h actual %h", $time, i, x.coeff[i],
                                 a.coeff[i]);
                        errors++;
                    end
                if (a.expw !== x.expw) begin
                    $display("%0t exponent: expected %h actual %h", $time, x.expw, a.expw);
                    errors++;
                end
                if (a.keep !== x.keep) begin
                    $display("%0t keep: expected %b actual %b", $time, x.keep, a.keep);
                    errors++;
                end
                if (a.last !== x.last) begin
                    $display("%0t last: expected %b actual %b", $time, x.last, a.last);
                    errors++;
                end
                if (a.count !== x.count) begin
                    $display("%0t kept_count: expected %0d actual %0d", $time, x.count,
                             a.count);
                    errors++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // long hold-off while the sender keeps offering
    initial begin
        hold_off = 0;
        wait (send_idle_pct == 1);
        repeat (50) @(posedge i_clk);
        hold_off <= 1;
        repeat (600) @(posedge i_clk);
        hold_off <= 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else if (pending_q.size() != 0 || (i_valid && !done_sending))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic random_phase(int n, int idle_pct, int stall_pct);
        t_deriv none;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_term(rand_term(i % 2), 1'b0, none);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    initial begin
        t_deriv none;
        i_rst_n = 0;
        i_valid = 0;
        i_coeff_0 = 0;
        i_coeff_1 = 0;
        i_coeff_2 = 0;
        i_coeff_3 = 0;
        i_exponent_word = 0;
        i_last_term = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_PRIME;
        i_cfg_data = 0;
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        done_sending = 0;
        m_prime = 64'd2;
        m_shift = 6'd0;
        m_width = 7'd8;
        m_kept = 32'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // after reset: p = 2, shift 0, width 8
        directed.push_back(mk(64'd1, 64'h1, 1'b0, 1'b1, 64'd1, 64'h0, 1'b1, 32'd1));
        directed.push_back(mk(64'd1, 64'h2, 1'b0, 1'b1, 64'd0, 64'd0, 1'b0, 32'd1));
        directed.push_back(mk(64'd0, 64'h0, 1'b0, 1'b1, 64'd0, 64'd0, 1'b0, 32'd1));
        directed.push_back(mk({64{1'b1}}, 64'h3, 1'b1, 1'b1, 64'd1, 64'h2, 1'b1, 32'd2));
        directed.push_back(mk(64'd1, 64'h101, 1'b0, 1'b1, 64'd1, 64'h100, 1'b1, 32'd1));
        directed.push_back(mk({64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1, 64'd1,
                              64'hffff_ffff_ffff_fffe, 1'b1, 32'd2));
        foreach (directed[i]) send_term(directed[i].t, directed[i].has_exp, directed[i].e);
        drain();

        // modulus zero: no reduction, products wrap
        write_reg(CFG_PRIME, 64'd0);
        write_reg(CFG_WIDTH, 64'd64);
        directed = {};
        directed.push_back(mk({64{1'b1}}, 64'd3, 1'b0, 1'b1, 64'hffff_ffff_ffff_fffd, 64'd2,
                              1'b1, 32'd1));
        directed.push_back(mk(64'd5, {64{1'b1}}, 1'b0, 1'b1, 64'hffff_ffff_ffff_fffb,
                              64'hffff_ffff_ffff_fffe, 1'b1, 32'd2));
        directed.push_back(mk(64'd5, 64'd0, 1'b1, 1'b1, 64'd0, 64'd0, 1'b0, 32'd2));
        foreach (directed[i]) send_term(directed[i].t, directed[i].has_exp, directed[i].e);
        drain();
        // modulus one drops everything; width 0 too
        write_reg(CFG_PRIME, 64'd1);
        send_term(rand_term(0), 1'b0, none);
        send_term(rand_term(0), 1'b0, none);
        drain();
        write_reg(CFG_PRIME, {64{1'b1}});
        write_reg(CFG_WIDTH, 64'd0);
        send_term(rand_term(0), 1'b0, none);
        drain();
        // wide field and field past bit 63
        write_reg(CFG_WIDTH, 64'd127);
        write_reg(CFG_SHIFT, 64'd63);
        directed = {};
        directed.push_back(mk(64'd2, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'd2, 64'd0,
                              1'b1, 32'd1));
        directed.push_back(mk(64'd2, 64'h7fff_ffff_ffff_ffff, 1'b1, 1'b1, 64'd0, 64'd0,
                              1'b0, 32'd1));
        foreach (directed[i]) send_term(directed[i].t, directed[i].has_exp, directed[i].e);
        drain();
        // residue not below p, field value equal to p
        write_reg(CFG_PRIME, 64'd7);
        write_reg(CFG_SHIFT, 64'd4);
        write_reg(CFG_WIDTH, 64'd4);
        directed = {};
        directed.push_back(mk(64'd10, 64'h30, 1'b0, 1'b1, 64'd2, 64'h20, 1'b1, 32'd1));
        directed.push_back(mk(64'd10, 64'h70, 1'b1, 1'b1, 64'd0, 64'd0, 1'b0, 32'd1));
        foreach (directed[i]) send_term(directed[i].t, directed[i].has_exp, directed[i].e);
        drain();

        // random phases across settings
        write_reg(CFG_PRIME, 64'hffff_ffff_ffff_ffc5);
        write_reg(CFG_SHIFT, 64'd8);
        write_reg(CFG_WIDTH, 64'd8);
        random_phase(200, 0, 0);
        write_reg(CFG_PRIME, 64'd13);
        write_reg(CFG_SHIFT, 64'd0);
        write_reg(CFG_WIDTH, 64'd3);
        random_phase(200, 68, 0);
        write_reg(CFG_PRIME, 64'd0);
        write_reg(CFG_SHIFT, 64'd60);
        write_reg(CFG_WIDTH, 64'd16);
        random_phase(200, 0, 68);
        write_reg(CFG_PRIME, {$urandom, $urandom} | 64'd2);
        write_reg(CFG_SHIFT, 64'd20);
        write_reg(CFG_WIDTH, 64'd64);
        random_phase(200, 35, 35);
        write_reg(CFG_PRIME, 64'd3);
        write_reg(CFG_SHIFT, 64'd1);
        write_reg(CFG_WIDTH, 64'd2);
        send_idle_pct = 1;
        random_phase(300, 1, 0);

        done_sending = 1;
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
